FILE: hdl/idqs_pkg.sv
// ----------------------------------------------------------------------------
// idqs_pkg
// Shared types and codes for the indexed deque with search.
// ----------------------------------------------------------------------------
`default_nettype none

package idqs_pkg;

  localparam int IN_W  = 48;  // opcode, position, item_value, zero fill
  localparam int RES_W = 48;  // packed result word

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_READ_AT    = 3'd2,
    OP_REMOVE_AT  = 3'd3,
    OP_FIND       = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // last member sits in the lowest bits
  typedef struct packed {
    logic        is_empty;
    logic [6:0]  entry_count;
    status_e     status;
    logic [5:0]  found_index;
    logic [31:0] read_value;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/idqs_mem.sv
// ----------------------------------------------------------------------------
// idqs_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module idqs_mem #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32,
  parameter int PW          = 6
) (
  input  wire logic                   clk_i,
  input  wire logic                   we_i,
  input  wire logic [PW-1:0]          waddr_i,
  input  wire logic [VALUE_WIDTH-1:0] wdata_i,
  input  wire logic                   re_i,
  input  wire logic [PW-1:0]          raddr_i,
  output      logic [VALUE_WIDTH-1:0] rdata_o
);

  logic [VALUE_WIDTH-1:0] mem_q [DEPTH];
  logic [VALUE_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/idqs_ctrl.sv
// ----------------------------------------------------------------------------
// idqs_ctrl
// Request sequencer: pointer and count, pushes, and the memory walk used by
// read, remove (shift down) and find.
// ----------------------------------------------------------------------------
`default_nettype none

module idqs_ctrl
  import idqs_pkg::*;
#(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32,
  parameter int PW          = 6,
  parameter int CW          = 7
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output      logic                   in_ready_o,
  input  wire op_e                    op_i,
  input  wire logic [5:0]             pos_i,
  input  wire logic [31:0]            val_i,
  output      logic                   mem_we_o,
  output      logic [PW-1:0]          mem_waddr_o,
  output      logic [VALUE_WIDTH-1:0] mem_wdata_o,
  output      logic                   mem_re_o,
  output      logic [PW-1:0]          mem_raddr_o,
  input  wire logic [VALUE_WIDTH-1:0] mem_rdata_i,
  output      logic                   res_valid_o,
  output      res_t                   res_o,
  input  wire logic                   res_ready_i
);

  localparam int XW = (CW > 6) ? CW : 6;
  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WALK, S_FIN} state_e;

  state_e                 state_q;
  op_e                    op_q;
  logic [5:0]             pos_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [PW-1:0]          front_q;
  logic [CW-1:0]          count_q;
  logic [CW-1:0]          rd_idx_q;
  logic [CW-1:0]          end_q;
  logic [PW-1:0]          rd_slot_q;
  logic                   first_q;
  logic                   pend_q;
  logic                   pend_first_q;
  logic [CW-1:0]          pend_idx_q;
  logic [PW-1:0]          pend_slot_q;
  logic [PW-1:0]          prev_slot_q;
  logic [31:0]            rv_q;
  logic [5:0]             found_q;
  status_e                status_q;

  // (base + idx) mod DEPTH, both below DEPTH or idx equal to it
  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base,
                                            input logic [CW-1:0] idx);
    logic [PW:0] sum;
    sum = {1'b0, base} + (PW+1)'(idx);
    if (sum >= (PW+1)'(DEPTH)) begin
      sum = sum - (PW+1)'(DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  logic          full;
  logic          in_range;
  logic [CW-1:0] pos_c;
  logic [PW-1:0] front_dec;
  logic [PW-1:0] back_slot;
  logic [PW-1:0] slot_inc;
  logic          match;
  logic          issue;

  assign full      = (count_q == DEPTH_C);
  assign in_range  = (XW'(pos_q) < XW'(count_q));
  assign pos_c     = CW'(pos_q);
  assign front_dec = (front_q == '0) ? LAST_SLOT : front_q - 1'b1;
  assign back_slot = slot_of(front_q, count_q);
  assign slot_inc  = (rd_slot_q == LAST_SLOT) ? '0 : rd_slot_q + 1'b1;
  assign match     = pend_q && (op_q == OP_FIND) && (mem_rdata_i == val_q);
  // reads run ahead of the write-back by two entries, so no overlap
  assign issue     = (state_q == S_WALK) && (rd_idx_q < end_q) && !match;

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = prev_slot_q;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = issue;
    mem_raddr_o = rd_slot_q;
    if (state_q == S_EXEC && !full) begin
      if (op_q == OP_PUSH_FRONT) begin
        mem_we_o    = 1'b1;
        mem_waddr_o = front_dec;
        mem_wdata_o = val_q;
      end else if (op_q == OP_PUSH_BACK) begin
        mem_we_o    = 1'b1;
        mem_waddr_o = back_slot;
        mem_wdata_o = val_q;
      end
    end else if (state_q == S_WALK && pend_q && !pend_first_q &&
                 op_q == OP_REMOVE_AT) begin
      mem_we_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_PUSH_FRONT;
      pos_q        <= '0;
      val_q        <= '0;
      front_q      <= '0;
      count_q      <= '0;
      rd_idx_q     <= '0;
      end_q        <= '0;
      rd_slot_q    <= '0;
      first_q      <= 1'b0;
      pend_q       <= 1'b0;
      pend_first_q <= 1'b0;
      pend_idx_q   <= '0;
      pend_slot_q  <= '0;
      prev_slot_q  <= '0;
      rv_q         <= '0;
      found_q      <= '0;
      status_q     <= ST_OK;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= op_i;
            pos_q   <= pos_i;
            val_q   <= VALUE_WIDTH'(val_i);
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          rv_q     <= '0;
          found_q  <= '0;
          status_q <= ST_OK;
          first_q  <= 1'b1;
          pend_q   <= 1'b0;
          state_q  <= S_FIN;
          unique case (op_q)
            OP_PUSH_FRONT: begin
              if (full) begin
                status_q <= ST_FULL;
              end else begin
                front_q <= front_dec;
                count_q <= count_q + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                status_q <= ST_FULL;
              end else begin
                count_q <= count_q + 1'b1;
              end
            end
            OP_READ_AT, OP_REMOVE_AT: begin
              if (!in_range) begin
                status_q <= ST_RANGE;
              end else begin
                rd_idx_q  <= pos_c;
                rd_slot_q <= slot_of(front_q, pos_c);
                end_q     <= (op_q == OP_READ_AT) ? pos_c + 1'b1 : count_q;
                state_q   <= S_WALK;
              end
            end
            OP_FIND: begin
              status_q  <= ST_NOTFOUND;
              rd_idx_q  <= '0;
              rd_slot_q <= front_q;
              end_q     <= count_q;
              state_q   <= S_WALK;
            end
            default: ;
          endcase
        end
        S_WALK: begin
          pend_q <= issue;
          if (issue) begin
            rd_idx_q     <= rd_idx_q + 1'b1;
            rd_slot_q    <= slot_inc;
            pend_idx_q   <= rd_idx_q;
            pend_slot_q  <= rd_slot_q;
            pend_first_q <= first_q;
            first_q      <= 1'b0;
          end
          if (pend_q) begin
            prev_slot_q <= pend_slot_q;
            if (pend_first_q && op_q != OP_FIND) begin
              rv_q <= 32'(mem_rdata_i);
            end
          end
          if (match) begin
            found_q  <= 6'(pend_idx_q);
            status_q <= ST_OK;
            state_q  <= S_FIN;
          end else if (!issue && !pend_q) begin
            if (op_q == OP_REMOVE_AT) begin
              count_q <= count_q - 1'b1;
            end
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_FIN);

  always_comb begin
    res_o.read_value  = rv_q;
    res_o.found_index = found_q;
    res_o.status      = status_q;
    res_o.entry_count = 7'(count_q);
    res_o.is_empty    = (count_q == '0);
  end

endmodule

`default_nettype wire

FILE: hdl/idqs_out.sv
// ----------------------------------------------------------------------------
// idqs_out
// Output register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module idqs_out
  import idqs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             res_valid_i,
  input  wire res_t             res_i,
  output      logic             res_ready_o,
  output      logic             m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output      logic [RES_W-1:0] m_axis_tdata
);

  logic             valid_q;
  logic [RES_W-1:0] data_q;

  assign res_ready_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;

endmodule

`default_nettype wire

FILE: hdl/indexed_deque_with_search_top.sv
// ----------------------------------------------------------------------------
// indexed_deque_with_search_top
// Deque of up to DEPTH values in a circular memory, with indexed read and
// removal and a linear search.
// ----------------------------------------------------------------------------
// Pushes, bad positions and unused opcodes go to the result without a memory
//   walk; a read, a remove (from the position to the end) and a find (up to the
//   first match) walk the memory, and the walk reads one entry per cycle.
// One request is in flight at a time; the next is taken once the previous
//   result has moved into the output register.
// Reset empties the store at once; memory contents are left as they are.
`default_nettype none

module indexed_deque_with_search_top
  import idqs_pkg::*;
#(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output      logic             s_axis_tready,
  // [2:0] opcode, [8:3] position, [40:9] item_value, [47:41] zero
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  output      logic             m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // [31:0] read_value, [37:32] found_index, [39:38] status,
  // [46:40] entry_count, [47] is_empty
  output      logic [RES_W-1:0] m_axis_tdata
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic                   mem_we;
  logic [PW-1:0]          mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic                   mem_re;
  logic [PW-1:0]          mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_rdata;
  logic                   res_valid;
  logic                   res_ready;
  res_t                   res;

  idqs_mem #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH),
    .PW         (PW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  idqs_ctrl #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH),
    .PW         (PW),
    .CW         (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (op_e'(s_axis_tdata[2:0])),
    .pos_i      (s_axis_tdata[8:3]),
    .val_i      (s_axis_tdata[40:9]),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_ready_i(res_ready)
  );

  idqs_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .res_ready_o  (res_ready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule

`default_nettype wire

FILE: hdl/idqs_checker.sv
// ----------------------------------------------------------------------------
// idqs_checker
// Port-level checks on the result stream of the deque.
// ----------------------------------------------------------------------------
`default_nettype none

module idqs_checker
  import idqs_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [RES_W-1:0] m_axis_tdata
);

  res_t res;
  assign res = m_axis_tdata;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.is_empty == (res.entry_count == 7'd0)))
    else $error("empty flag disagrees with entry count");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.status == ST_FULL |-> res.entry_count == 7'(DEPTH))
    else $error("full status with store not full");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.status != ST_OK |-> res.found_index == 6'd0 &&
      res.read_value == 32'd0)
    else $error("failed request carries data");

endmodule

bind indexed_deque_with_search_top idqs_checker #(.DEPTH(DEPTH)) u_idqs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
